/* sv/mcc_pkg.sv */
// Shared constants, types and a clamping helper function for the multichannel convolution block.
package mcc_pkg;

    localparam int MAX_KERNEL   = 5;
    localparam int MAX_WIDTH    = 32;
    localparam int MAX_HEIGHT   = 32;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_FILTERS  = 8;

    localparam int WT_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int LB_DEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int PS_DEPTH = MAX_FILTERS * MAX_HEIGHT * MAX_WIDTH;

    localparam int WT_AW   = $clog2(WT_DEPTH);
    localparam int LB_AW   = $clog2(LB_DEPTH);
    localparam int PS_AW   = $clog2(PS_DEPTH);
    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int F_W     = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int SLOT_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int TAP_W   = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int ACC_W   = 40;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_HEIGHT   = 3'd0,
        CFG_WIDTH    = 3'd1,
        CFG_CHANNELS = 3'd2,
        CFG_FILTERS  = 3'd3,
        CFG_KERNEL   = 3'd4
    } cfg_idx_t;

    // Input item kinds.
    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_BIAS   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_ISSUE,
        S_DRAIN,
        S_PSRD,
        S_PSWR,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              lb_we;
        logic [LB_AW-1:0]  lb_addr;
        logic              wt_we;
        logic [WT_AW-1:0]  wt_addr;
        logic              bias_we;
        logic [F_W-1:0]    bias_idx;
        logic [15:0]       wdata;
        logic              mac_en;
        logic              acc_clr;
        logic [PS_AW-1:0]  ps_addr;
        logic              ps_we;
        logic              first_ch;
        logic              emit;
        logic [F_W-1:0]    filt;
        logic [ROW_W-1:0]  orow;
        logic [COL_W-1:0]  ocol;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    // Zero counts as one, values above the limit count as the limit.
    function automatic logic [8:0] clamp_reg(input logic [8:0] v, input logic [8:0] hi);
        logic [8:0] r;
        if (v == 9'd0)
            r = 9'd1;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

/* sv/mcc_ctrl.sv */
// Controller: configuration registers, stream counters and the sequencing state machine.
module mcc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [2:0]            cfg_index,
    input  logic [5:0]            cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [9:0]            s_index,
    input  logic [15:0]           s_value,
    output mcc_pkg::cmd_t         cmd,
    input  mcc_pkg::status_t      status
);
    import mcc_pkg::*;

    state_t state_reg, state_next;

    logic [5:0] height_reg, width_reg;
    logic [2:0] chans_reg, kern_reg;
    logic [3:0] filts_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [ROW_W-1:0]  orow_reg, orow_next;
    logic [COL_W-1:0]  ocol_reg, ocol_next;
    logic [CH_W-1:0]   wch_reg, wch_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [SLOT_W-1:0] ii_reg, ii_next;
    logic [SLOT_W-1:0] jj_reg, jj_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic [F_W-1:0]    filt_reg, filt_next;
    logic [WT_AW-1:0]  wbase_reg, wbase_next;
    logic              dcnt_reg, dcnt_next;

    logic [8:0] h, w, c, nf, k;
    logic [8:0] kk;
    logic       accept, is_pixel, window;
    logic [SLOT_W-1:0] start_slot;

    // Clamped configuration.
    assign h  = clamp_reg({3'd0, height_reg}, 9'(MAX_HEIGHT));
    assign w  = clamp_reg({3'd0, width_reg}, 9'(MAX_WIDTH));
    assign c  = clamp_reg({6'd0, chans_reg}, 9'(MAX_CHANNELS));
    assign nf = clamp_reg({5'd0, filts_reg}, 9'(MAX_FILTERS));
    assign k  = clamp_reg({6'd0, kern_reg}, 9'(MAX_KERNEL));
    assign kk = 9'(k * k);

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_pixel = (s_kind == OP_PIXEL);
    assign window   = (9'(row_reg) + 9'd1 >= k) && (9'(col_reg) + 9'd1 >= k);
    assign start_slot = (9'(slot_reg) + 9'd1 == k) ? '0 : SLOT_W'(slot_reg + 1'b1);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= 6'd28;
            width_reg  <= 6'd28;
            chans_reg  <= 3'd1;
            filts_reg  <= 4'd3;
            kern_reg   <= 3'd3;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HEIGHT:   height_reg <= cfg_data;
                CFG_WIDTH:    width_reg  <= cfg_data;
                CFG_CHANNELS: chans_reg  <= cfg_data[2:0];
                CFG_FILTERS:  filts_reg  <= cfg_data[3:0];
                CFG_KERNEL:   kern_reg   <= cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            ch_reg    <= '0;
            slot_reg  <= '0;
            orow_reg  <= '0;
            ocol_reg  <= '0;
            wch_reg   <= '0;
            wslot_reg <= '0;
            rslot_reg <= '0;
            ii_reg    <= '0;
            jj_reg    <= '0;
            tap_reg   <= '0;
            filt_reg  <= '0;
            wbase_reg <= '0;
            dcnt_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            orow_reg  <= orow_next;
            ocol_reg  <= ocol_next;
            wch_reg   <= wch_next;
            wslot_reg <= wslot_next;
            rslot_reg <= rslot_next;
            ii_reg    <= ii_next;
            jj_reg    <= jj_next;
            tap_reg   <= tap_next;
            filt_reg  <= filt_next;
            wbase_reg <= wbase_next;
            dcnt_reg  <= dcnt_next;
            // Any register write restarts the image.
            if (cfg_valid && cfg_index <= CFG_KERNEL)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                ch_reg   <= '0;
                slot_reg <= '0;
            end
            else
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                ch_reg   <= ch_next;
                slot_reg <= slot_next;
            end
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        ch_next    = ch_reg;
        slot_next  = slot_reg;
        orow_next  = orow_reg;
        ocol_next  = ocol_reg;
        wch_next   = wch_reg;
        wslot_next = wslot_reg;
        rslot_next = rslot_reg;
        ii_next    = ii_reg;
        jj_next    = jj_reg;
        tap_next   = tap_reg;
        filt_next  = filt_reg;
        wbase_next = wbase_reg;
        dcnt_next  = dcnt_reg;

        cmd          = '0;
        cmd.wdata    = s_value;
        cmd.bias_idx = F_W'(s_index);
        cmd.filt     = filt_reg;
        cmd.orow     = orow_reg;
        cmd.ocol     = ocol_reg;
        cmd.first_ch = (wch_reg == '0);
        cmd.last     = (9'(filt_reg) + 9'd1 == nf);
        cmd.ps_addr  = PS_AW'((PS_AW'(filt_reg) * PS_AW'(MAX_HEIGHT) + PS_AW'(orow_reg))
                              * PS_AW'(MAX_WIDTH) + PS_AW'(ocol_reg));
        cmd.wt_addr  = WT_AW'(wbase_reg + WT_AW'(tap_reg));
        cmd.lb_addr  = LB_AW'(LB_AW'(rslot_reg) * LB_AW'(MAX_WIDTH)
                              + LB_AW'(ocol_reg) + LB_AW'(jj_reg));

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (s_kind == OP_WEIGHT)
                    begin
                        cmd.wt_addr = WT_AW'(s_index);
                        cmd.wt_we   = (s_index < 10'(WT_DEPTH));
                    end
                    else if (s_kind == OP_BIAS)
                    begin
                        cmd.bias_we = (s_index < 10'(MAX_FILTERS));
                    end
                    else if (is_pixel)
                    begin
                        cmd.lb_we   = 1'b1;
                        cmd.lb_addr = LB_AW'(LB_AW'(slot_reg) * LB_AW'(MAX_WIDTH)
                                             + LB_AW'(col_reg));
                        // Window position for this pixel.
                        orow_next  = ROW_W'(9'(row_reg) + 9'd1 - k);
                        ocol_next  = COL_W'(9'(col_reg) + 9'd1 - k);
                        wch_next   = ch_reg;
                        wslot_next = start_slot;
                        filt_next  = '0;
                        if (window)
                            state_next = S_CLR;
                        // Advance the raster counters.
                        if (9'(col_reg) + 9'd1 >= w)
                        begin
                            col_next = '0;
                            if (9'(row_reg) + 9'd1 >= h)
                            begin
                                row_next  = '0;
                                slot_next = '0;
                                ch_next   = (9'(ch_reg) + 9'd1 >= c) ? '0
                                                                     : CH_W'(ch_reg + 1'b1);
                            end
                            else
                            begin
                                row_next  = ROW_W'(row_reg + 1'b1);
                                slot_next = (9'(slot_reg) + 9'd1 >= k) ? '0
                                                                       : SLOT_W'(slot_reg + 1'b1);
                            end
                        end
                        else
                        begin
                            col_next = COL_W'(col_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CLR:
            begin
                cmd.acc_clr = 1'b1;
                wbase_next  = WT_AW'(WT_AW'(9'(filt_reg) * c + 9'(wch_reg)) * WT_AW'(kk));
                rslot_next  = wslot_reg;
                ii_next     = '0;
                jj_next     = '0;
                tap_next    = '0;
                state_next  = S_ISSUE;
            end
            S_ISSUE:
            begin
                // One tap read per cycle, row by row through the window.
                cmd.mac_en = 1'b1;
                tap_next   = TAP_W'(tap_reg + 1'b1);
                if (9'(jj_reg) + 9'd1 == k)
                begin
                    jj_next    = '0;
                    rslot_next = (9'(rslot_reg) + 9'd1 == k) ? '0 : SLOT_W'(rslot_reg + 1'b1);
                    ii_next    = SLOT_W'(ii_reg + 1'b1);
                    if (9'(ii_reg) + 9'd1 == k)
                    begin
                        dcnt_next  = 1'b0;
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    jj_next = SLOT_W'(jj_reg + 1'b1);
                end
            end
            S_DRAIN:
            begin
                dcnt_next = 1'b1;
                if (dcnt_reg)
                    state_next = S_PSRD;
            end
            S_PSRD:
            begin
                state_next = S_PSWR;
            end
            S_PSWR:
            begin
                cmd.ps_we = 1'b1;
                if (9'(wch_reg) + 9'd1 == c)
                    state_next = S_EMIT;
                else if (9'(filt_reg) + 9'd1 == nf)
                    state_next = S_IDLE;
                else
                begin
                    filt_next  = F_W'(filt_reg + 1'b1);
                    state_next = S_CLR;
                end
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit = 1'b1;
                    if (9'(filt_reg) + 9'd1 == nf)
                        state_next = S_IDLE;
                    else
                    begin
                        filt_next  = F_W'(filt_reg + 1'b1);
                        state_next = S_CLR;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/mcc_dp.sv */
// Datapath: weight, bias, line and partial-sum stores, the shared MAC and the output register.
module mcc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  mcc_pkg::cmd_t     cmd,
    output mcc_pkg::status_t  status,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [47:0]       m_data,
    output logic              m_last
);
    import mcc_pkg::*;

    logic signed [15:0] wt_mem [WT_DEPTH];
    logic signed [15:0] lb_mem [LB_DEPTH];
    logic signed [ACC_W-1:0] ps_mem [PS_DEPTH];
    logic signed [15:0] bias_reg [MAX_FILTERS];

    logic signed [15:0]      wt_q_reg, lb_q_reg;
    logic signed [ACC_W-1:0] ps_q_reg;
    logic                    v1_reg, v2_reg;
    logic signed [31:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg, sum_reg, sum_new;

    logic                    out_valid_reg;
    logic [F_W-1:0]          out_filt_reg;
    logic [ROW_W-1:0]        out_row_reg;
    logic [COL_W-1:0]        out_col_reg;
    logic signed [31:0]      out_sum_reg;
    logic                    out_last_reg;

    logic signed [ACC_W:0]   total;
    logic signed [31:0]      sat;

    // Weight store.
    always_ff @(posedge clk)
    begin
        if (cmd.wt_we)
            wt_mem[cmd.wt_addr] <= cmd.wdata;
        wt_q_reg <= wt_mem[cmd.wt_addr];
    end

    // Line buffer.
    always_ff @(posedge clk)
    begin
        if (cmd.lb_we)
            lb_mem[cmd.lb_addr] <= cmd.wdata;
        lb_q_reg <= lb_mem[cmd.lb_addr];
    end

    // Bias registers.
    always_ff @(posedge clk)
    begin
        if (cmd.bias_we)
            bias_reg[cmd.bias_idx] <= cmd.wdata;
    end

    // Partial-sum store; the first channel overwrites.
    assign sum_new = cmd.first_ch ? acc_reg : ps_q_reg + acc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ps_we)
        begin
            ps_mem[cmd.ps_addr] <= sum_new;
            sum_reg             <= sum_new;
        end
        ps_q_reg <= ps_mem[cmd.ps_addr];
    end

    // Multiply-accumulate pipeline: read, multiply, add.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.mac_en;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 32'(lb_q_reg * wt_q_reg);
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // Bias in Q8.8, shifted up to the Q16.16 sum, and saturation to 32 bits.
    always_comb
    begin
        total = (ACC_W+1)'(sum_reg) + ((ACC_W+1)'(bias_reg[cmd.filt]) <<< 8);
        if (total > (ACC_W+1)'(33'sh0_7FFF_FFFF))
            sat = 32'sh7FFF_FFFF;
        else if (total < -(ACC_W+1)'(33'sh0_8000_0000))
            sat = 32'sh8000_0000;
        else
            sat = 32'(total);
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_filt_reg <= cmd.filt;
            out_row_reg  <= cmd.orow;
            out_col_reg  <= cmd.ocol;
            out_sum_reg  <= sat;
            out_last_reg <= cmd.last;
        end
    end

    assign status.out_busy = out_valid_reg && !m_ready;
    assign m_valid = out_valid_reg;
    assign m_last  = out_last_reg;
    assign m_data  = {3'd0, out_sum_reg, 5'(out_col_reg), 5'(out_row_reg), 3'(out_filt_reg)};

endmodule

/* sv/multichannel_conv2d.sv */
// Top level of the multichannel valid 2D convolution block.
//
//  channel | direction | handshake                  | contents
//  cfg     | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//  s       | in        | s_tvalid / s_tready        | s_tuser operation, s_tdata index, value
//  m       | out       | m_tvalid / m_tready        | m_tdata result fields, m_tlast
//
// Loads and pixels without a full window are handled in the accepting idle state. A
// pixel that completes a window then runs each filter in turn on the single shared MAC:
// clear, tap issue, drain, partial-sum read and write, and on the last channel an emit
// that waits while the output register is full.
// Reset clears configuration to its defaults and the stream counters to zero.
// Input stalls while an item is in work; the output register frees the MAC early.
module multichannel_conv2d (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // index [9:0], value [25:10], zero [31:26]
    input  logic [1:0]  s_tuser,   // operation [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // filter_index [2:0], out_row [7:3], out_col [12:8],
                                   // sum_out [44:13], zero [47:45]
    output logic        m_tlast    // last_of_run
);
    import mcc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Configuration is taken at any time.
    assign cfg_ready = 1'b1;

    mcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_kind    (s_tuser),
        .s_index   (s_tdata[9:0]),
        .s_value   (s_tdata[25:10]),
        .cmd       (cmd),
        .status    (status)
    );

    mcc_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata),
        .m_last  (m_tlast)
    );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the multichannel valid 2D convolution block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mcc_pkg::*;

    // Operation code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 300;
    // Weights loaded up front; every tested setting reads only below this address.
    localparam int WT_USED = 50;
    localparam int ITEM_TARGET = 300;

    typedef struct {
        bit [2:0]  filt;
        bit [4:0]  orow;
        bit [4:0]  ocol;
        bit [31:0] sum;
        bit        last;
    } conv_result_t;

    // Scoreboard: keeps its own copy of the block state and predicts every result.
    class conv_scoreboard;
        bit [5:0] reg_h, reg_w;
        bit [2:0] reg_c, reg_k;
        bit [3:0] reg_f;
        shortint  weights[WT_DEPTH];
        shortint  biases[MAX_FILTERS];
        shortint  lines[LB_DEPTH];
        longint   sums[PS_DEPTH];
        int       col_cnt, row_cnt, ch_cnt;
        conv_result_t pending_q[$];
        int       errors, checked, predicted;

        function new();
            reg_h = 6'd28;
            reg_w = 6'd28;
            reg_c = 3'd1;
            reg_f = 4'd3;
            reg_k = 3'd3;
        endfunction

        function int lim(int v, int hi);
            if (v == 0)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        // A register write also restarts the image at channel 0, row 0, column 0.
        function void write_reg(cfg_idx_t idx, bit [5:0] data);
            case (idx)
                CFG_HEIGHT:   reg_h = data;
                CFG_WIDTH:    reg_w = data;
                CFG_CHANNELS: reg_c = data[2:0];
                CFG_FILTERS:  reg_f = data[3:0];
                CFG_KERNEL:   reg_k = data[2:0];
                default: ;
            endcase
            col_cnt = 0;
            row_cnt = 0;
            ch_cnt  = 0;
        endfunction

        // Note one accepted item and queue the results it causes.
        function void note_input(logic [1:0] op, logic [9:0] idx, logic [15:0] val);
            int h, w, c, nf, k, orow, ocol, slot, wa, pidx;
            longint dot, total;
            conv_result_t r;
            if (op == OP_WEIGHT) begin
                if (idx < WT_DEPTH)
                    weights[idx] = val;
                return;
            end
            if (op == OP_BIAS) begin
                if (idx < MAX_FILTERS)
                    biases[idx] = val;
                return;
            end
            if (op != OP_PIXEL)
                return;
            h  = lim(reg_h, MAX_HEIGHT);
            w  = lim(reg_w, MAX_WIDTH);
            c  = lim(reg_c, MAX_CHANNELS);
            nf = lim(reg_f, MAX_FILTERS);
            k  = lim(reg_k, MAX_KERNEL);
            if (row_cnt >= h || col_cnt >= w || ch_cnt >= c) begin
                row_cnt = 0;
                col_cnt = 0;
                ch_cnt  = 0;
            end
            lines[(row_cnt % k) * MAX_WIDTH + col_cnt] = val;
            // A complete window: one dot product per filter.
            if (row_cnt + 1 >= k && col_cnt + 1 >= k) begin
                orow = row_cnt + 1 - k;
                ocol = col_cnt + 1 - k;
                for (int f = 0; f < nf; f++) begin
                    dot = 0;
                    for (int i = 0; i < k; i++) begin
                        slot = ((orow + i) % k) * MAX_WIDTH;
                        for (int j = 0; j < k; j++) begin
                            wa = ((f * c + ch_cnt) * k + i) * k + j;
                            dot += longint'(lines[slot + ocol + j]) * longint'(weights[wa]);
                        end
                    end
                    pidx = (f * MAX_HEIGHT + orow) * MAX_WIDTH + ocol;
                    if (ch_cnt == 0)
                        sums[pidx] = dot;
                    else
                        sums[pidx] += dot;
                    if (ch_cnt + 1 == c) begin
                        total = sums[pidx] + longint'(biases[f]) * 256;
                        if (total > 64'sd2147483647)
                            total = 64'sd2147483647;
                        else if (total < -64'sd2147483648)
                            total = -64'sd2147483648;
                        r.filt = 3'(f);
                        r.orow = 5'(orow);
                        r.ocol = 5'(ocol);
                        r.sum  = total[31:0];
                        r.last = (f + 1 == nf);
                        pending_q.push_back(r);
                        predicted++;
                    end
                end
            end
            // Advance column, row and channel.
            col_cnt++;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
                if (row_cnt >= h) begin
                    row_cnt = 0;
                    ch_cnt++;
                    if (ch_cnt >= c)
                        ch_cnt = 0;
                end
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one accepted result with the oldest expectation.
        task check_result(bit [2:0] filt, bit [4:0] orow, bit [4:0] ocol,
                          bit [31:0] sum, bit last);
            conv_result_t e;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result filter %0d row %0d col %0d",
                                 filt, orow, ocol));
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (filt != e.filt || orow != e.orow || ocol != e.ocol || sum != e.sum
                || last != e.last)
                report($sformatf("got f%0d r%0d c%0d s%08h l%0d, want f%0d r%0d c%0d s%08h l%0d",
                                 filt, orow, ocol, sum, last,
                                 e.filt, e.orow, e.ocol, e.sum, e.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [5:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;

    conv_scoreboard sb;
    bit stream_on;
    bit hold_req;
    int burst_left;
    int items_sent;
    int phases;

    multichannel_conv2d u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #15ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: check accepted results and stall on a shifting pattern.
    initial
    begin
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[2:0], m_tdata[7:3], m_tdata[12:8],
                                m_tdata[44:13], m_tlast);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 2000;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (mode == 0)
                m_tready <= 1'b1;
            else if (mode == 1)
                m_tready <= 1'($urandom_range(0, 1));
            else
                m_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Offer one item and wait for it to be taken; bursts end in random gaps, some of them empty.
    task automatic send_item(logic [1:0] op, logic [9:0] idx, logic [15:0] val);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, val, idx};
        stream_on = 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, idx, val);
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                stream_on = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Let every expected result arrive and the block settle.
    task automatic drain();
        if (stream_on)
        begin
            s_tvalid <= 1'b0;
            stream_on = 1'b0;
        end
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five registers back to back while the block is idle.
    task automatic write_regs(bit [5:0] h, bit [5:0] w, bit [5:0] c, bit [5:0] f,
                              bit [5:0] k);
        bit [5:0] vals[5];
        vals = '{h, w, c, f, k};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(cfg_idx_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
        phases++;
    endtask

    task automatic send_pixels(int count, logic [15:0] val);
        for (int i = 0; i < count; i++)
            send_item(OP_PIXEL, 10'd0, val);
    endtask

    task automatic send_random_pixels(int count);
        for (int i = 0; i < count; i++)
            send_item(OP_PIXEL, 10'($urandom), 16'($urandom));
    endtask

    // Stimulus.
    initial
    begin
        int h, w, c, f, k, npix;
        sb = new();
        stream_on = 1'b0;
        hold_req = 1'b0;
        burst_left = 1;
        items_sent = 0;
        phases = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_HEIGHT;
        cfg_data = 6'd0;
        s_tvalid = 1'b0;
        s_tdata = 32'd0;
        s_tuser = OP_PIXEL;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every weight and bias that the tested settings can read.
        for (int i = 0; i < WT_USED; i++)
            send_item(OP_WEIGHT, 10'(i), 16'($urandom));
        for (int i = 0; i < MAX_FILTERS; i++)
            send_item(OP_BIAS, 10'(i), 16'($urandom));
        drain();

        // Saturation both ways on a 1x1 image with four channels, plus ignored loads.
        write_regs(6'd1, 6'd1, 6'd4, 6'd2, 6'd1);
        for (int i = 0; i < 4; i++)
        begin
            send_item(OP_WEIGHT, 10'(i), 16'h8000);
            send_item(OP_WEIGHT, 10'(i + 4), 16'h7FFF);
        end
        send_item(OP_BIAS, 10'd0, 16'h7FFF);
        send_item(OP_BIAS, 10'd1, 16'h8000);
        send_item(OP_WEIGHT, 10'd800, 16'h1234);
        send_item(OP_WEIGHT, 10'h3FF, 16'hFFFF);
        send_item(OP_BIAS, 10'd8, 16'h4321);
        send_item(OP_BIAS, 10'h3FF, 16'hFFFF);
        send_item(OP_UNUSED, 10'h3FF, 16'hFFFF);
        send_pixels(4, 16'h8000);
        drain();

        // Zero and oversized register values clamp; the receiver holds off for a while.
        write_regs(6'd0, 6'd63, 6'd0, 6'd15, 6'd0);
        hold_req = 1'b1;
        send_random_pixels(32);
        drain();

        // Kernel larger than the image gives no result; then a tall 1x1-kernel column.
        write_regs(6'd63, 6'd1, 6'd7, 6'd1, 6'd7);
        send_random_pixels(8);
        drain();
        write_regs(6'd32, 6'd1, 6'd1, 6'd1, 6'd1);
        send_random_pixels(32);
        drain();

        // Largest kernel accumulated over two channels.
        write_regs(6'd5, 6'd5, 6'd2, 6'd1, 6'd5);
        send_random_pixels(50);
        drain();

        // Random phases with loads, reloads and unused items mixed into the pixels.
        while (items_sent < ITEM_TARGET)
        begin
            do
            begin
                c = $urandom_range(0, 5);
                f = $urandom_range(0, 9);
                k = $urandom_range(0, 4);
            end
            while (sb.lim(c, MAX_CHANNELS) * sb.lim(f, MAX_FILTERS) * sb.lim(k, MAX_KERNEL)
                   * sb.lim(k, MAX_KERNEL) > WT_USED);
            h = $urandom_range(1, 4);
            w = $urandom_range(1, 4);
            write_regs(6'(h), 6'(w), 6'(c), 6'(f), 6'(k));
            npix = sb.lim(c, MAX_CHANNELS) * h * w * $urandom_range(1, 2);
            if (npix > 3 && $urandom_range(0, 3) == 0)
                npix -= $urandom_range(1, 3);
            for (int i = 0; i < npix; i++)
            begin
                case ($urandom_range(0, 24))
                    0, 1: send_item(OP_WEIGHT, 10'($urandom_range(0, 1023)), 16'($urandom));
                    2:    send_item(OP_BIAS, 10'($urandom_range(0, 15)), 16'($urandom));
                    3:    send_item(OP_UNUSED, 10'($urandom), 16'($urandom));
                    default: ;
                endcase
                send_item(OP_PIXEL, 10'($urandom), 16'($urandom));
            end
            drain();
        end

        $display("Run covered %0d items over %0d register settings.", items_sent, phases);
        $display("Results checked: %0d, mismatches: %0d.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* multichannel_conv2d.f */
sv/mcc_pkg.sv
sv/mcc_ctrl.sv
sv/mcc_dp.sv
sv/multichannel_conv2d.sv
tb/sv/tb_top.sv
